### rtl/mhb_pkg.sv
// ----------------------------------------------------------------------------
// mhb_pkg: shared types and constants for the magnetometer heading block
// Holds the item structs, the controller state type, the command bundle
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mhb_pkg;

  // Width of the CORDIC x/y working registers: 16 data bits, 16 fraction
  // bits from the prescale, and headroom for the CORDIC gain and sign.
  localparam int CORDIC_W  = 36;
  // Width of the angle accumulator (centidegrees times 2^16).
  localparam int ACC_W     = 32;
  // Number of entries in the arctangent table and the width of its index.
  localparam int ATAN_LEN  = 24;
  localparam int IDX_W     = 5;

  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 32'sd589824000;  // 9000 << 16
  localparam logic signed [16:0]      HEADING_MAX  = 17'sd18000;
  localparam logic signed [16:0]      HEADING_MIN  = -17'sd18000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic signed [15:0] heading_centideg;
    logic signed [15:0] x_axis;
    logic signed [15:0] y_axis;
    logic signed [15:0] z_axis;
  } out_t;

  // Position of a byte within the six-byte burst.
  typedef enum logic [2:0] {
    POS_XH = 3'd0,
    POS_XL = 3'd1,
    POS_ZH = 3'd2,
    POS_ZL = 3'd3,
    POS_YH = 3'd4,
    POS_YL = 3'd5
  } byte_pos_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER,
    S_FINAL,
    S_HOLD
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             asm_en;    // store the incoming byte
    byte_pos_e        asm_pos;   // where the byte goes
    logic             start;     // capture the axes and load the CORDIC
    logic             step_en;   // perform one micro-rotation
    logic [IDX_W-1:0] step_idx;  // index of that micro-rotation
    logic             out_load;  // round, clamp and register the result
  } cmd_t;

  // atan(2^-i) in centidegrees times 2^16, rounded to nearest.
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'sd294912000;
      5'd1:    v = 32'sd174096719;
      5'd2:    v = 32'sd91987925;
      5'd3:    v = 32'sd46694507;
      5'd4:    v = 32'sd23437865;
      5'd5:    v = 32'sd11730358;
      5'd6:    v = 32'sd5866610;
      5'd7:    v = 32'sd2933484;
      5'd8:    v = 32'sd1466764;
      5'd9:    v = 32'sd733385;
      5'd10:   v = 32'sd366693;
      5'd11:   v = 32'sd183346;
      5'd12:   v = 32'sd91673;
      5'd13:   v = 32'sd45837;
      5'd14:   v = 32'sd22918;
      5'd15:   v = 32'sd11459;
      5'd16:   v = 32'sd5730;
      5'd17:   v = 32'sd2865;
      5'd18:   v = 32'sd1432;
      5'd19:   v = 32'sd716;
      5'd20:   v = 32'sd358;
      5'd21:   v = 32'sd179;
      5'd22:   v = 32'sd90;
      5'd23:   v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/mhb_datapath.sv
// ----------------------------------------------------------------------------
// mhb_datapath: byte assembly, CORDIC vectoring unit and result register
// Executes the controller's commands; one micro-rotation per step command.
// ----------------------------------------------------------------------------
module mhb_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mhb_pkg::cmd_t cmd_i,
  input  logic [7:0]    byte_i,
  output mhb_pkg::out_t out_o
);

  logic [15:0] x_word_q, z_word_q;
  logic [7:0]  y_hi_q;
  logic [15:0] raw_x_q, raw_y_q, raw_z_q;
  logic        zero_q;

  logic signed [mhb_pkg::CORDIC_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [mhb_pkg::ACC_W-1:0]    acc_q, acc_d;
  mhb_pkg::out_t                       out_q;

  logic [15:0]                         y_word;
  logic signed [mhb_pkg::CORDIC_W-1:0] ld_x, ld_y, dx, dy;
  logic signed [mhb_pkg::ACC_W-1:0]    ang;
  logic signed [mhb_pkg::ACC_W:0]      rsum;
  logic signed [16:0]                  rnd, clamped;

  // Burst assembly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_word_q <= '0;
      z_word_q <= '0;
      y_hi_q   <= '0;
    end else if (cmd_i.asm_en) begin
      unique case (cmd_i.asm_pos)
        mhb_pkg::POS_XH: x_word_q <= {byte_i, 8'h00};
        mhb_pkg::POS_XL: x_word_q <= x_word_q | {8'h00, byte_i};
        mhb_pkg::POS_ZH: z_word_q <= {byte_i, 8'h00};
        mhb_pkg::POS_ZL: z_word_q <= z_word_q | {8'h00, byte_i};
        mhb_pkg::POS_YH: y_hi_q   <= byte_i;
        default: ;
      endcase
    end
  end

  assign y_word = {y_hi_q, byte_i};
  assign ld_x   = {{(mhb_pkg::CORDIC_W-32){x_word_q[15]}}, x_word_q, 16'h0000};
  assign ld_y   = {{(mhb_pkg::CORDIC_W-32){y_word[15]}}, y_word, 16'h0000};

  // Floor shifts of the working values for the current step.
  assign dx  = cy_q >>> cmd_i.step_idx;
  assign dy  = cx_q >>> cmd_i.step_idx;
  assign ang = mhb_pkg::atan_entry(cmd_i.step_idx);

  always_comb begin
    cx_d  = cx_q;
    cy_d  = cy_q;
    acc_d = acc_q;
    if (cmd_i.start) begin
      // Bring a left half plane vector over by a quarter turn.
      if (ld_x < 0) begin
        if (ld_y >= 0) begin
          cx_d  = ld_y;
          cy_d  = -ld_x;
          acc_d = mhb_pkg::QUARTER_TURN;
        end else begin
          cx_d  = -ld_y;
          cy_d  = ld_x;
          acc_d = -mhb_pkg::QUARTER_TURN;
        end
      end else begin
        cx_d  = ld_x;
        cy_d  = ld_y;
        acc_d = '0;
      end
    end else if (cmd_i.step_en) begin
      if (!cy_q[mhb_pkg::CORDIC_W-1]) begin
        cx_d  = cx_q + dx;
        cy_d  = cy_q - dy;
        acc_d = acc_q + ang;
      end else begin
        cx_d  = cx_q - dx;
        cy_d  = cy_q + dy;
        acc_d = acc_q - ang;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    acc_q <= acc_d;
    if (cmd_i.start) begin
      raw_x_q <= x_word_q;
      raw_y_q <= y_word;
      raw_z_q <= z_word_q;
      zero_q  <= (x_word_q == 16'h0000) && (y_word == 16'h0000);
    end
  end

  // Round to nearest with ties upward, then clamp to a half turn.
  assign rsum = $signed({acc_q[mhb_pkg::ACC_W-1], acc_q}) + 33'sd32768;
  assign rnd  = rsum[mhb_pkg::ACC_W:16];

  always_comb begin
    if (rnd > mhb_pkg::HEADING_MAX) begin
      clamped = mhb_pkg::HEADING_MAX;
    end else if (rnd < mhb_pkg::HEADING_MIN) begin
      clamped = mhb_pkg::HEADING_MIN;
    end else begin
      clamped = rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.heading_centideg <= zero_q ? 16'sd0 : clamped[15:0];
      out_q.x_axis           <= raw_x_q;
      out_q.y_axis           <= raw_y_q;
      out_q.z_axis           <= raw_z_q;
    end
  end

  assign out_o = out_q;

endmodule

### rtl/mhb_ctrl.sv
// ----------------------------------------------------------------------------
// mhb_ctrl: burst position tracking and CORDIC sequencing
// Issues assembly, start, step and result commands to the datapath.
// ----------------------------------------------------------------------------
module mhb_ctrl #(
  parameter int NumSteps = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          frame_start_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mhb_pkg::cmd_t cmd_o
);

  localparam int StepW = $clog2(NumSteps);

  mhb_pkg::ctl_state_e state_q, state_d;
  mhb_pkg::byte_pos_e  pos_q, pos_d, pos_cur;
  logic [StepW-1:0]    iter_q, iter_d;
  logic                in_acc, last_step;

  // The final byte must wait until the CORDIC unit and result register are free.
  assign in_stall_o = (pos_q == mhb_pkg::POS_YL) && (state_q != mhb_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_cur    = frame_start_i ? mhb_pkg::POS_XH : pos_q;
  assign last_step  = (iter_q == StepW'(NumSteps - 1));

  always_comb begin
    pos_d = pos_q;
    if (in_acc) begin
      pos_d = (pos_cur == mhb_pkg::POS_YL) ? mhb_pkg::POS_XH
                                            : mhb_pkg::byte_pos_e'(pos_cur + 3'd1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    unique case (state_q)
      mhb_pkg::S_IDLE: begin
        if (in_acc && (pos_cur == mhb_pkg::POS_YL)) begin
          state_d = mhb_pkg::S_ITER;
          iter_d  = '0;
        end
      end
      mhb_pkg::S_ITER: begin
        if (last_step) begin
          state_d = mhb_pkg::S_FINAL;
        end else begin
          iter_d = iter_q + StepW'(1);
        end
      end
      mhb_pkg::S_FINAL: state_d = mhb_pkg::S_HOLD;
      mhb_pkg::S_HOLD: begin
        if (!out_stall_i) begin
          state_d = mhb_pkg::S_IDLE;
        end
      end
      default: state_d = mhb_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.asm_en   = in_acc;
    cmd_o.asm_pos  = pos_cur;
    cmd_o.start    = in_acc && (pos_cur == mhb_pkg::POS_YL);
    cmd_o.step_idx = mhb_pkg::IDX_W'(iter_q);
    out_valid_o    = 1'b0;
    unique case (state_q)
      mhb_pkg::S_IDLE:  ;
      mhb_pkg::S_ITER:  cmd_o.step_en  = 1'b1;
      mhb_pkg::S_FINAL: cmd_o.out_load = 1'b1;
      mhb_pkg::S_HOLD:  out_valid_o    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhb_pkg::S_IDLE;
      pos_q   <= mhb_pkg::POS_XH;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      iter_q  <= iter_d;
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> (state_q == mhb_pkg::S_IDLE))
    else $error("CORDIC restarted while busy");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mhb_pkg::S_ITER) |-> (iter_q <= StepW'(NumSteps - 1)))
    else $error("step counter out of range");

  a_final_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mhb_pkg::S_FINAL) |=> out_valid_o)
    else $error("result not presented after final step");

  a_step_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == mhb_pkg::S_ITER) && (iter_q == '0))
    else $error("iteration did not begin at step zero");

endmodule

### rtl/magnetometer_heading_from_bytes.sv
// ----------------------------------------------------------------------------
// magnetometer_heading_from_bytes: compass heading from a magnetometer burst
// Assembles X, Z and Y words from six bytes and computes atan2(Y, X) in
// hundredths of a degree with an iterative CORDIC in vectoring mode.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    mhb_pkg::in_t  (byte, start flag)
//   out      output     out_valid_o / out_stall_i  mhb_pkg::out_t (heading, axes)
//
// Bytes one through five of a burst are taken one per cycle and cause no result.
// The sixth byte starts the CORDIC unit, which does min(CORDIC_STEPS, 24)
// micro-rotations, one per cycle, then registers the result and raises out_valid_o.
// While the unit runs or the result waits, the first five bytes of the next burst
// are still taken; only the next sixth byte is stalled until the result leaves.
// Reset clears the burst position and the sequencer; no result is pending after it.
// A start flag on any byte restarts assembly with that byte as the X high byte.
//
module magnetometer_heading_from_bytes #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mhb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mhb_pkg::out_t out_data_o
);

  // The table holds 24 angles, so at most that many steps are done.
  localparam int NumSteps = (CORDIC_STEPS > mhb_pkg::ATAN_LEN) ? mhb_pkg::ATAN_LEN
                                                               : CORDIC_STEPS;

  mhb_pkg::cmd_t cmd;

  mhb_ctrl #(
    .NumSteps(NumSteps)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .frame_start_i(in_data_i.frame_start),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd)
  );

  mhb_datapath u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .byte_i(in_data_i.data_byte),
    .out_o (out_data_o)
  );

endmodule
